// ===== hw/rtl/shss_pkg.sv =====
// ----------------------------------------------------------------------------
// shss_pkg: half-step sequencer shared types and constants
// Holds the command codes, the stream field widths and the coil pattern
// lookup for the half-step sequencer.
// ----------------------------------------------------------------------------
package shss_pkg;

  // Field widths of the input and result words
  localparam int CmdW    = 3;
  localparam int StepW   = 16;
  localparam int TargetW = 32;
  localparam int CoilW   = 4;
  localparam int OutPosW = 32;
  localparam int PhaseW  = 3;

  // Packed word widths, padded to whole bytes
  localparam int InFieldsW  = CmdW + StepW + TargetW;
  localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int OutFieldsW = CoilW + OutPosW + OutPosW + 1;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Command codes; codes five to seven are ignored
  typedef enum logic [CmdW-1:0] {
    CMD_TICK     = 3'd0,
    CMD_FORWARD  = 3'd1,
    CMD_BACK     = 3'd2,
    CMD_ABSOLUTE = 3'd3,
    CMD_STOP     = 3'd4
  } cmd_e;

  // Half-step coil pattern for a phase index
  function automatic logic [CoilW-1:0] coil_lookup(input logic [PhaseW-1:0] phase);
    logic [CoilW-1:0] pat;
    case (phase)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

// ===== hw/rtl/stepper_half_step_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_half_step_sequencer_unit: four-coil half-step stepper sequencer
// Takes tick and move commands on a stream input and returns the coil
// pattern, position, remaining count and running flag after each word.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command word per transfer (tick, move forward, move
//   back, move absolute, stop). Every accepted word yields exactly one
//   result word on m_axis with the state after that command.
//   A move only loads the signed remaining count and sets running; the
//   motor steps one half step on each later tick while running. A tick
//   with nothing left clears running.
//   Timing: an accepted word is held in the input register, and its result
//   is then registered in the result register and presented on m_axis.
//   Throughput: one word per cycle unless m_axis stalls; the state update
//   is a single add per counter between the input and result registers.
//   Stall: while m_axis is stalled the result register holds; the input
//   register takes a word only while empty, then s_axis_tready_o drops.
//   Reset: coils off, phase, position and count zero, stopped, both
//   stages empty.
module stepper_half_step_sequencer_unit #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata, lsb up: command[2:0], step_count[18:3], target_position[50:19]
  input  logic [shss_pkg::InDataW-1:0]  s_axis_tdata_i,
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata, lsb up: coil_pattern[3:0], current_position[35:4],
  //   steps_remaining[67:36], running[68]
  output logic [shss_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int PosW = POSITION_WIDTH;

  // Input register
  logic                                in_valid_q;
  logic [shss_pkg::CmdW-1:0]           cmd_q;
  logic [shss_pkg::StepW-1:0]          step_q;
  logic signed [shss_pkg::TargetW-1:0] target_q;

  // Motor state
  logic [shss_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [shss_pkg::CoilW-1:0]  coil_q, coil_d;
  logic [PosW-1:0]             rem_q, rem_d;
  logic [PosW-1:0]             pos_q, pos_d;
  logic                        run_q, run_d;

  // Result register
  logic                          out_valid_q;
  logic [shss_pkg::OutDataW-1:0] out_data_q;

  logic advance;
  logic in_load;
  logic [PosW-1:0] steps_ext;
  logic [PosW-1:0] target_ext;
  logic [shss_pkg::PhaseW-1:0] phase_fwd, phase_bwd;

  // Handshake: input stage moves on when the result register frees up
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_load         = s_axis_tvalid_i && s_axis_tready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      cmd_q    <= s_axis_tdata_i[shss_pkg::CmdW-1:0];
      step_q   <= s_axis_tdata_i[shss_pkg::CmdW +: shss_pkg::StepW];
      target_q <= s_axis_tdata_i[shss_pkg::CmdW + shss_pkg::StepW +: shss_pkg::TargetW];
    end
  end

  // Operands brought to state width (target sign-extended)
  assign steps_ext  = PosW'(step_q);
  assign target_ext = PosW'(target_q);
  assign phase_fwd  = phase_q + shss_pkg::PhaseW'(1);
  assign phase_bwd  = phase_q - shss_pkg::PhaseW'(1);

  // Next state for the word in the input register
  always_comb begin
    phase_d = phase_q;
    coil_d  = coil_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    run_d   = run_q;
    case (cmd_q)
      shss_pkg::CMD_TICK: begin
        if (run_q) begin
          if (rem_q == '0) begin
            run_d = 1'b0;
          end else if (!rem_q[PosW-1]) begin
            phase_d = phase_fwd;
            coil_d  = shss_pkg::coil_lookup(phase_fwd);
            rem_d   = rem_q - PosW'(1);
            pos_d   = pos_q + PosW'(1);
          end else begin
            phase_d = phase_bwd;
            coil_d  = shss_pkg::coil_lookup(phase_bwd);
            rem_d   = rem_q + PosW'(1);
            pos_d   = pos_q - PosW'(1);
          end
        end
      end
      shss_pkg::CMD_FORWARD: begin
        rem_d = steps_ext;
        run_d = 1'b1;
      end
      shss_pkg::CMD_BACK: begin
        rem_d = '0 - steps_ext;
        run_d = 1'b1;
      end
      shss_pkg::CMD_ABSOLUTE: begin
        rem_d = target_ext - pos_q;
        run_d = 1'b1;
      end
      shss_pkg::CMD_STOP: begin
        run_d = 1'b0;
      end
      default: begin
        // unused codes leave the state alone
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      coil_q  <= '0;
      rem_q   <= '0;
      pos_q   <= '0;
      run_q   <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      coil_q  <= coil_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
      run_q   <= run_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= shss_pkg::OutDataW'({run_d,
                                         shss_pkg::OutPosW'(rem_d),
                                         shss_pkg::OutPosW'(pos_d),
                                         coil_d});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Checks
  a_move_sets_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (cmd_q == shss_pkg::CMD_FORWARD || cmd_q == shss_pkg::CMD_BACK ||
                cmd_q == shss_pkg::CMD_ABSOLUTE) |=> run_q)
    else $error("move did not set running");

  a_phase_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cmd_q != shss_pkg::CMD_TICK |=> $stable(phase_q) && $stable(pos_q))
    else $error("phase or position changed on a non-tick word");

  a_coil_pattern_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coil_q == '0 || $countones(coil_q) == 1 || $countones(coil_q) == 2)
    else $error("illegal coil pattern");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid_o)
    else $error("result missing after input stage advanced");

  a_stopped_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !run_q |=> $stable(pos_q))
    else $error("position moved while stopped");

endmodule
